### rtl/core/ftrs_pkg.sv
// ----------------------------------------------------------------------------
// ftrs_pkg
// Shared types, constants and the arctangent table for the face steering block.
// ----------------------------------------------------------------------------
package ftrs_pkg;

  // default parameter values
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_BITS_DEF    = 16;
  localparam int TABLE_LEN         = 24;

  // angle accumulator width, 1/32768 degree units
  localparam int Z_W   = 26;
  // rounded angle width, 1/128 degree units
  localparam int ANG_W = 18;
  // configuration word width
  localparam int CFG_W = 16;

  localparam logic signed [Z_W-1:0]   FINE_HALF_TURN = Z_W'(5898240);
  localparam logic signed [ANG_W-1:0] FULL_TURN      = ANG_W'(46080);
  localparam logic signed [ANG_W-1:0] HALF_TURN      = ANG_W'(23040);
  localparam logic signed [ANG_W-1:0] QUARTER_TURN   = ANG_W'(11520);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FACE_TOWARD = 2'd0,
    REG_VIEW_ANGLE  = 2'd1,
    REG_OUTER_VIEW  = 2'd2,
    REG_TIME_VIEW   = 2'd3
  } cfg_reg_t;

  // steering zone
  typedef enum logic [1:0] {
    ZONE_STOP = 2'd0,
    ZONE_SLOW = 2'd1,
    ZONE_FAST = 2'd2
  } zone_t;

  // rounded atan(2^-i) in 1/32768 degree units
  function automatic logic [Z_W-1:0] atan_fine(input int i);
    logic [Z_W-1:0] v;
    unique case (i)
      0:  v = Z_W'(1474560);
      1:  v = Z_W'(870484);
      2:  v = Z_W'(459940);
      3:  v = Z_W'(233473);
      4:  v = Z_W'(117189);
      5:  v = Z_W'(58652);
      6:  v = Z_W'(29333);
      7:  v = Z_W'(14667);
      8:  v = Z_W'(7334);
      9:  v = Z_W'(3667);
      10: v = Z_W'(1833);
      11: v = Z_W'(917);
      12: v = Z_W'(458);
      13: v = Z_W'(229);
      14: v = Z_W'(115);
      15: v = Z_W'(57);
      16: v = Z_W'(29);
      17: v = Z_W'(14);
      18: v = Z_W'(7);
      19: v = Z_W'(4);
      20: v = Z_W'(2);
      21: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/face_target_rotation_steer.sv
// ----------------------------------------------------------------------------
// face_target_rotation_steer
// Face steering: turns the owner's heading toward or away from a target with
// a rotational acceleration picked from stop, slow and fast zones.
// ----------------------------------------------------------------------------
// Pipeline: input register, CORDIC cell row, R1, R2, R3, divider row one
//   (15 cells), S, divider row two (24 cells) and the output register, from
//   start to out_valid.
// Throughput: one word per cycle; busy stays low.
// Reset: synchronous, active low; clears the pipeline valids and loads the
//   configuration defaults. Results are strobed for one cycle, no stall.
module face_target_rotation_steer #(
  parameter int CORDIC_STAGES = ftrs_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_BITS    = ftrs_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_owner_x,
  input  logic signed [COORD_BITS-1:0] in_owner_y,
  input  logic signed [COORD_BITS-1:0] in_target_x,
  input  logic signed [COORD_BITS-1:0] in_target_y,
  input  logic signed [COORD_BITS-1:0] in_heading_x,
  input  logic signed [COORD_BITS-1:0] in_heading_y,
  input  logic signed [15:0]           in_turn_rate,
  input  logic [14:0]                  in_max_turn_rate,
  output logic                         out_valid,
  output logic signed [15:0]           out_turn_accel,
  output logic signed [15:0]           out_turn_rate_out,
  output logic                         out_stopped,
  input  logic                         cfg_we,
  input  ftrs_pkg::cfg_reg_t           cfg_index,
  input  logic [ftrs_pkg::CFG_W-1:0]   cfg_wdata
);
  import ftrs_pkg::*;

  localparam int N    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int CW   = COORD_BITS + 5;
  localparam int SB_C = 33;
  localparam int SB_D = 35;

  // ---------------- configuration registers ----------------
  logic        face_toward_r;
  logic [14:0] view_angle_r;
  logic [14:0] outer_view_r;
  logic [15:0] time_to_view_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_toward_r  <= 1'b1;
      view_angle_r   <= 15'd128;
      outer_view_r   <= 15'd1280;
      time_to_view_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FACE_TOWARD: face_toward_r  <= cfg_wdata[0];
        REG_VIEW_ANGLE:  view_angle_r   <= cfg_wdata[14:0];
        REG_OUTER_VIEW:  outer_view_r   <= cfg_wdata[14:0];
        REG_TIME_VIEW:   time_to_view_r <= cfg_wdata;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- input stage: vectors and half-plane fold ----------------
  logic signed [CW-1:0]  dx_w, dy_w, ax_w, ay_w, bx_w, by_w;
  logic                  accept;

  assign accept = start && !busy;

  always_comb begin
    if (face_toward_r) begin
      dx_w = CW'(in_target_x) - CW'(in_owner_x);
      dy_w = CW'(in_target_y) - CW'(in_owner_y);
    end else begin
      dx_w = CW'(in_owner_x) - CW'(in_target_x);
      dy_w = CW'(in_owner_y) - CW'(in_target_y);
    end
    ax_w = CW'(in_heading_x);
    ay_w = CW'(in_heading_y);
    bx_w = dx_w;
    by_w = -dy_w;
  end

  logic                  c_valid [0:N];
  logic signed [CW-1:0]  c_ax [0:N];
  logic signed [CW-1:0]  c_ay [0:N];
  logic signed [Z_W-1:0] c_az [0:N];
  logic signed [CW-1:0]  c_bx [0:N];
  logic signed [CW-1:0]  c_by [0:N];
  logic signed [Z_W-1:0] c_bz [0:N];
  logic [SB_C-1:0]       c_sb [0:N];

  logic                  p_valid_r;
  logic signed [CW-1:0]  p_ax_r, p_ay_r, p_bx_r, p_by_r;
  logic signed [Z_W-1:0] p_az_r, p_bz_r;
  logic [SB_C-1:0]       p_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= accept;
    end
  end

  // vectors in the left half-plane are negated and start at 180 degrees
  always_ff @(posedge clk) begin
    p_ax_r <= (ax_w < 0) ? -ax_w : ax_w;
    p_ay_r <= (ax_w < 0) ? -ay_w : ay_w;
    p_az_r <= (ax_w < 0) ? FINE_HALF_TURN : '0;
    p_bx_r <= (bx_w < 0) ? -bx_w : bx_w;
    p_by_r <= (bx_w < 0) ? -by_w : by_w;
    p_bz_r <= (bx_w < 0) ? FINE_HALF_TURN : '0;
    p_sb_r <= {(ax_w == 0 && ay_w == 0), (bx_w == 0 && by_w == 0),
               in_turn_rate, in_max_turn_rate};
  end

  assign c_valid[0] = p_valid_r;
  assign c_ax[0]    = p_ax_r;
  assign c_ay[0]    = p_ay_r;
  assign c_az[0]    = p_az_r;
  assign c_bx[0]    = p_bx_r;
  assign c_by[0]    = p_by_r;
  assign c_bz[0]    = p_bz_r;
  assign c_sb[0]    = p_sb_r;

  // ---------------- CORDIC cell row ----------------
  for (genvar i = 0; i < N; i++) begin : g_cordic
    ftrs_cordic_cell #(.STAGE(i), .CW(CW), .SB_W(SB_C)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[i]),
      .in_ax     (c_ax[i]),
      .in_ay     (c_ay[i]),
      .in_az     (c_az[i]),
      .in_bx     (c_bx[i]),
      .in_by     (c_by[i]),
      .in_bz     (c_bz[i]),
      .in_sb     (c_sb[i]),
      .out_valid (c_valid[i+1]),
      .out_ax    (c_ax[i+1]),
      .out_ay    (c_ay[i+1]),
      .out_az    (c_az[i+1]),
      .out_bx    (c_bx[i+1]),
      .out_by    (c_by[i+1]),
      .out_bz    (c_bz[i+1]),
      .out_sb    (c_sb[i+1])
    );
  end

  // ---------------- R1: round angles and reduce to one turn ----------------
  logic signed [Z_W-1:0]   az_rnd, bz_rnd;
  logic signed [ANG_W-1:0] own_raw, pt_raw, own_w, pt_w;
  logic                    r1_valid_r;
  logic signed [ANG_W-1:0] own_r, pt_r;
  logic [30:0]             r1_sb_r;

  always_comb begin
    az_rnd  = c_az[N] + Z_W'(128);
    bz_rnd  = c_bz[N] + Z_W'(128);
    own_raw = (c_sb[N][32] ? '0 : $signed(az_rnd[Z_W-1:8])) + QUARTER_TURN;
    pt_raw  = c_sb[N][31] ? '0 : $signed(bz_rnd[Z_W-1:8]);
    if (own_raw >= FULL_TURN) begin
      own_w = own_raw - FULL_TURN;
    end else if (own_raw < 0) begin
      own_w = own_raw + FULL_TURN;
    end else begin
      own_w = own_raw;
    end
    if (pt_raw >= FULL_TURN) begin
      pt_w = pt_raw - FULL_TURN;
    end else if (pt_raw < 0) begin
      pt_w = pt_raw + FULL_TURN;
    end else begin
      pt_w = pt_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_valid_r <= 1'b0;
    end else begin
      r1_valid_r <= c_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    own_r   <= own_w;
    pt_r    <= pt_w;
    r1_sb_r <= c_sb[N][30:0];
  end

  // ---------------- R2: wrapped difference and magnitude ----------------
  logic signed [ANG_W-1:0] d_raw, d_w, mag_w;
  logic                    r2_valid_r;
  logic [14:0]             mag_r;
  logic                    neg_r, pos_r;
  logic [30:0]             r2_sb_r;

  always_comb begin
    d_raw = own_r - pt_r;
    if (d_raw >= HALF_TURN) begin
      d_w = d_raw - FULL_TURN;
    end else if (d_raw < -HALF_TURN) begin
      d_w = d_raw + FULL_TURN;
    end else begin
      d_w = d_raw;
    end
    mag_w = (d_w < 0) ? -d_w : d_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_valid_r <= 1'b0;
    end else begin
      r2_valid_r <= r1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_w[14:0];
    neg_r   <= (d_w < 0);
    pos_r   <= (d_w > 0);
    r2_sb_r <= r1_sb_r;
  end

  // ---------------- R3: zone select and scaled target rate ----------------
  zone_t       zone_w;
  logic        r3_valid_r;
  logic [29:0] prod_r;
  logic [SB_D-1:0] r3_sb_r;

  always_comb begin
    priority if (mag_r < view_angle_r) begin
      zone_w = ZONE_STOP;
    end else if (mag_r < outer_view_r) begin
      zone_w = ZONE_SLOW;
    end else begin
      zone_w = ZONE_FAST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r3_valid_r <= 1'b0;
    end else begin
      r3_valid_r <= r2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= 30'(r2_sb_r[14:0]) * 30'(mag_r);
    r3_sb_r <= {zone_w, neg_r, pos_r, r2_sb_r};
  end

  // ---------------- divider row one: max_rate * |d| / outer ----------------
  logic            d1_valid [0:15];
  logic [14:0]     d1_rem [0:15];
  logic [14:0]     d1_sh [0:15];
  logic [SB_D-1:0] d1_sb [0:15];

  // quotient fits 15 bits in the slow zone, so the upper half starts as remainder
  assign d1_valid[0] = r3_valid_r;
  assign d1_rem[0]   = prod_r[29:15];
  assign d1_sh[0]    = prod_r[14:0];
  assign d1_sb[0]    = r3_sb_r;

  for (genvar i = 0; i < 15; i++) begin : g_div1
    ftrs_div_cell #(.DW(15), .NW(15), .SB_W(SB_D)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (d1_valid[i]),
      .in_rem    (d1_rem[i]),
      .in_sh     (d1_sh[i]),
      .in_sb     (d1_sb[i]),
      .divisor   (outer_view_r),
      .out_valid (d1_valid[i+1]),
      .out_rem   (d1_rem[i+1]),
      .out_sh    (d1_sh[i+1]),
      .out_sb    (d1_sb[i+1])
    );
  end

  // ---------------- S: rate error, scaled by 256 ----------------
  logic signed [17:0] v_w, diff_w, absd_w;
  logic               s_valid_r;
  logic [23:0]        num_r;
  logic [SB_D-1:0]    s_sb_r;
  logic [15:0]        ttv_eff;

  always_comb begin
    v_w    = d1_sb[15][32] ? -18'(d1_sh[15]) : 18'(d1_sh[15]);
    diff_w = v_w - 18'($signed(d1_sb[15][30:15]));
    absd_w = (diff_w < 0) ? -diff_w : diff_w;
  end

  assign ttv_eff = (time_to_view_r == '0) ? 16'd1 : time_to_view_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= d1_valid[15];
    end
  end

  // sideband: zone, error sign, d > 0, rate, max rate
  always_ff @(posedge clk) begin
    num_r  <= {absd_w[15:0], 8'd0};
    s_sb_r <= {d1_sb[15][34:33], (diff_w < 0), d1_sb[15][31:0]};
  end

  // ---------------- divider row two: error * 256 / time_to_view ----------------
  logic            d2_valid [0:24];
  logic [15:0]     d2_rem [0:24];
  logic [23:0]     d2_sh [0:24];
  logic [SB_D-1:0] d2_sb [0:24];

  assign d2_valid[0] = s_valid_r;
  assign d2_rem[0]   = '0;
  assign d2_sh[0]    = num_r;
  assign d2_sb[0]    = s_sb_r;

  for (genvar i = 0; i < 24; i++) begin : g_div2
    ftrs_div_cell #(.DW(16), .NW(24), .SB_W(SB_D)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (d2_valid[i]),
      .in_rem    (d2_rem[i]),
      .in_sh     (d2_sh[i]),
      .in_sb     (d2_sb[i]),
      .divisor   (ttv_eff),
      .out_valid (d2_valid[i+1]),
      .out_rem   (d2_rem[i+1]),
      .out_sh    (d2_sh[i+1]),
      .out_sb    (d2_sb[i+1])
    );
  end

  // ---------------- output stage: zone result and saturation ----------------
  zone_t              o_zone;
  logic [23:0]        q2;
  logic signed [15:0] accel_w, rate_w, slow_w;
  logic               stop_w;
  logic [15:0]        maxr_w;

  always_comb begin
    o_zone = zone_t'(d2_sb[24][34:33]);
    q2     = d2_sh[24];
    maxr_w = {1'b0, d2_sb[24][14:0]};
    if (d2_sb[24][32]) begin
      slow_w = (q2 > 24'd32768) ? 16'sh8000 : -$signed(q2[15:0]);
    end else begin
      slow_w = (q2 > 24'd32767) ? 16'sh7fff : $signed(q2[15:0]);
    end
    unique case (o_zone)
      ZONE_STOP: begin
        accel_w = '0;
        rate_w  = '0;
        stop_w  = 1'b1;
      end
      ZONE_SLOW: begin
        accel_w = slow_w;
        rate_w  = $signed(d2_sb[24][30:15]);
        stop_w  = 1'b0;
      end
      ZONE_FAST: begin
        accel_w = d2_sb[24][31] ? $signed(maxr_w) : -$signed(maxr_w);
        rate_w  = $signed(d2_sb[24][30:15]);
        stop_w  = 1'b0;
      end
      default: begin
        accel_w = '0;
        rate_w  = '0;
        stop_w  = 1'b0;
      end
    endcase
  end

  logic               o_valid_r;
  logic signed [15:0] o_accel_r, o_rate_r;
  logic               o_stop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= d2_valid[24];
    end
  end

  always_ff @(posedge clk) begin
    o_accel_r <= accel_w;
    o_rate_r  <= rate_w;
    o_stop_r  <= stop_w;
  end

  assign out_valid         = o_valid_r;
  assign out_turn_accel    = o_accel_r;
  assign out_turn_rate_out = o_rate_r;
  assign out_stopped       = o_stop_r;

endmodule

### rtl/core/ftrs_cordic_cell.sv
// ----------------------------------------------------------------------------
// ftrs_cordic_cell
// One vectoring CORDIC micro-rotation, applied to two vectors side by side.
// ----------------------------------------------------------------------------
module ftrs_cordic_cell #(
  parameter int STAGE = 0,
  parameter int CW    = 21,
  parameter int SB_W  = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [CW-1:0]          in_ax,
  input  logic signed [CW-1:0]          in_ay,
  input  logic signed [ftrs_pkg::Z_W-1:0] in_az,
  input  logic signed [CW-1:0]          in_bx,
  input  logic signed [CW-1:0]          in_by,
  input  logic signed [ftrs_pkg::Z_W-1:0] in_bz,
  input  logic [SB_W-1:0]               in_sb,
  output logic                          out_valid,
  output logic signed [CW-1:0]          out_ax,
  output logic signed [CW-1:0]          out_ay,
  output logic signed [ftrs_pkg::Z_W-1:0] out_az,
  output logic signed [CW-1:0]          out_bx,
  output logic signed [CW-1:0]          out_by,
  output logic signed [ftrs_pkg::Z_W-1:0] out_bz,
  output logic [SB_W-1:0]               out_sb
);
  import ftrs_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = $signed(atan_fine(STAGE));

  logic                  valid_r;
  logic signed [CW-1:0]  ax_r, ay_r, bx_r, by_r;
  logic signed [Z_W-1:0] az_r, bz_r;
  logic [SB_W-1:0]       sb_r;
  logic signed [CW-1:0]  ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic signed [Z_W-1:0] az_nxt, bz_nxt;

  // rotate toward the x axis
  always_comb begin
    if (in_ay > 0) begin
      ax_nxt = in_ax + (in_ay >>> STAGE);
      ay_nxt = in_ay - (in_ax >>> STAGE);
      az_nxt = in_az + ATAN;
    end else begin
      ax_nxt = in_ax - (in_ay >>> STAGE);
      ay_nxt = in_ay + (in_ax >>> STAGE);
      az_nxt = in_az - ATAN;
    end
    if (in_by > 0) begin
      bx_nxt = in_bx + (in_by >>> STAGE);
      by_nxt = in_by - (in_bx >>> STAGE);
      bz_nxt = in_bz + ATAN;
    end else begin
      bx_nxt = in_bx - (in_by >>> STAGE);
      by_nxt = in_by + (in_bx >>> STAGE);
      bz_nxt = in_bz - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
    az_r <= az_nxt;
    bx_r <= bx_nxt;
    by_r <= by_nxt;
    bz_r <= bz_nxt;
    sb_r <= in_sb;
  end

  assign out_valid = valid_r;
  assign out_ax    = ax_r;
  assign out_ay    = ay_r;
  assign out_az    = az_r;
  assign out_bx    = bx_r;
  assign out_by    = by_r;
  assign out_bz    = bz_r;
  assign out_sb    = sb_r;

endmodule

### rtl/core/ftrs_div_cell.sv
// ----------------------------------------------------------------------------
// ftrs_div_cell
// One restoring division step: brings down one dividend bit, emits one
// quotient bit into the same shift register.
// ----------------------------------------------------------------------------
module ftrs_div_cell #(
  parameter int DW   = 16,
  parameter int NW   = 24,
  parameter int SB_W = 35
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [DW-1:0]   in_rem,
  input  logic [NW-1:0]   in_sh,
  input  logic [SB_W-1:0] in_sb,
  input  logic [DW-1:0]   divisor,
  output logic            out_valid,
  output logic [DW-1:0]   out_rem,
  output logic [NW-1:0]   out_sh,
  output logic [SB_W-1:0] out_sb
);

  logic            valid_r;
  logic [DW-1:0]   rem_r;
  logic [NW-1:0]   sh_r;
  logic [SB_W-1:0] sb_r;
  logic [DW:0]     trial;
  logic            ge;
  logic [DW-1:0]   rem_nxt;
  logic [NW-1:0]   sh_nxt;

  // trial subtract
  always_comb begin
    trial   = {in_rem, in_sh[NW-1]};
    ge      = (trial >= {1'b0, divisor});
    rem_nxt = ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
    sh_nxt  = {in_sh[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    sb_r  <= in_sb;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_sh    = sh_r;
  assign out_sb    = sb_r;

endmodule

### rtl/core/ftrs_checker.sv
// ----------------------------------------------------------------------------
// ftrs_checker
// Port-level checks for the face steering block, bound to the top level.
// ----------------------------------------------------------------------------
module ftrs_checker #(
  parameter int CORDIC_STAGES = ftrs_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_BITS    = ftrs_pkg::COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic signed [15:0]           in_turn_rate,
  input logic                         out_valid,
  input logic signed [15:0]           out_turn_accel,
  input logic signed [15:0]           out_turn_rate_out,
  input logic                         out_stopped
);
  import ftrs_pkg::*;

  localparam int N   = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int LAT = N + 45;

  // a stopped word carries no motion
  a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped |-> out_turn_accel == 0 && out_turn_rate_out == 0)
    else $error("stopped word with motion");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("word out right after reset");

  // every word comes from an accepted word at fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("word without matching start");

  // rate passes through when not stopped
  a_rate_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stopped |-> out_turn_rate_out == $past(in_turn_rate, LAT))
    else $error("turn rate not carried through");

  // block never stalls
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind face_target_rotation_steer ftrs_checker #(
  .CORDIC_STAGES (CORDIC_STAGES),
  .COORD_BITS    (COORD_BITS)
) u_ftrs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_turn_rate      (in_turn_rate),
  .out_valid         (out_valid),
  .out_turn_accel    (out_turn_accel),
  .out_turn_rate_out (out_turn_rate_out),
  .out_stopped       (out_stopped)
);

### dv/face_target_rotation_steer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_target_rotation_steer_test
// Self-checking bench for the face steering block. Words are driven with
// random gaps through the start/busy handshake, each accepted word is run
// through a bit-true CORDIC and zone predictor, and every strobed result is
// compared field by field in order. Register settings change between phases
// once the pipeline has drained.
// ----------------------------------------------------------------------------
module face_target_rotation_steer_test;
  import ftrs_pkg::*;

  localparam int LATENCY   = 61;
  localparam int STAGES    = 16;
  localparam int WDOG_MAX  = 5000;
  localparam longint TURN  = 46080;
  localparam longint HALF  = 23040;
  localparam longint QUART = 11520;
  localparam longint HALF_FINE = 5898240;
  localparam longint ATAN_TAB [24] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0};

  typedef struct packed {
    logic signed [15:0] ox, oy, tx, ty, hx, hy, rate;
    logic [14:0]        maxr;
  } steer_in_t;

  typedef struct packed {
    logic signed [15:0] accel;
    logic signed [15:0] rate;
    logic               stopped;
  } steer_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_owner_x = '0, in_owner_y = '0, in_target_x = '0;
  logic signed [15:0] in_target_y = '0, in_heading_x = '0, in_heading_y = '0;
  logic signed [15:0] in_turn_rate = '0;
  logic [14:0]        in_max_turn_rate = '0;
  logic               out_valid;
  logic signed [15:0] out_turn_accel, out_turn_rate_out;
  logic               out_stopped;
  logic               cfg_we = 1'b0;
  cfg_reg_t           cfg_index = REG_FACE_TOWARD;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  // local copy of the registers
  logic        face_toward_q;
  logic [14:0] view_q, outer_q;
  logic [15:0] ttv_q;

  steer_out_t steer_q [$];
  int mismatches = 0;
  int wdog = 0;
  logic accepted_now = 1'b0;

  face_target_rotation_steer uut (
    .clk, .rst_n, .start, .busy,
    .in_owner_x, .in_owner_y, .in_target_x, .in_target_y,
    .in_heading_x, .in_heading_y, .in_turn_rate, .in_max_turn_rate,
    .out_valid, .out_turn_accel, .out_turn_rate_out, .out_stopped,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  // vectoring CORDIC, result in 1/128 degree, not reduced
  function automatic longint cordic_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_FINE;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[i];
      end
    end
    return (z + 128) >>> 8;
  endfunction

  function automatic longint reduce_turn(longint a);
    a = a % TURN;
    if (a < 0) a = a + TURN;
    return a;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // steering zone decision and acceleration for one word
  function automatic steer_out_t steer_predict(steer_in_t w);
    steer_out_t r;
    longint dx, dy, own, brg, d, mag, v, ttv, maxr;
    maxr = w.maxr;
    if (face_toward_q) begin
      dx = longint'(w.tx) - w.ox;
      dy = longint'(w.ty) - w.oy;
    end else begin
      dx = longint'(w.ox) - w.tx;
      dy = longint'(w.oy) - w.ty;
    end
    own = reduce_turn(cordic_angle(w.hy, w.hx) + QUART);
    brg = reduce_turn(cordic_angle(-dy, dx));
    d = own - brg;
    if (d >= HALF) d = d - TURN;
    if (d < -HALF) d = d + TURN;
    mag = (d < 0) ? -d : d;
    r.rate = w.rate;
    r.stopped = 1'b0;
    if (mag < longint'(view_q)) begin
      r.accel = '0;
      r.rate = '0;
      r.stopped = 1'b1;
    end else if (mag < longint'(outer_q)) begin
      ttv = (ttv_q == 0) ? 1 : ttv_q;
      v = (maxr * mag) / longint'(outer_q);
      if (d < 0) v = -v;
      r.accel = clamp16(((v - w.rate) * 256) / ttv);
    end else begin
      r.accel = clamp16(d > 0 ? maxr : -maxr);
    end
    return r;
  endfunction

  // drive one word and wait for it to be taken
  task automatic send_word(steer_in_t w);
    int gap;
    gap = $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    {in_owner_x, in_owner_y, in_target_x, in_target_y} <= {w.ox, w.oy, w.tx, w.ty};
    {in_heading_x, in_heading_y, in_turn_rate} <= {w.hx, w.hy, w.rate};
    in_max_turn_rate <= w.maxr;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    steer_q.push_back(steer_predict(w));
    accepted_now = 1'b1;
  endtask

  // let the pipeline empty before touching the registers
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    wait (steer_q.size() == 0);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic load_regs(logic [15:0] face, logic [15:0] view, logic [15:0] outer,
                           logic [15:0] ttv);
    cfg_reg_t idx [4] = '{REG_FACE_TOWARD, REG_VIEW_ANGLE, REG_OUTER_VIEW, REG_TIME_VIEW};
    logic [15:0] val [4];
    val = '{face, view, outer, ttv};
    drain();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    face_toward_q = face[0];
    view_q = view[14:0];
    outer_q = outer[14:0];
    ttv_q = ttv;
  endtask

  function automatic logic signed [15:0] any16();
    return 16'($urandom_range(0, 65535));
  endfunction

  // heading lined up on the bearing, with a random tilt
  function automatic steer_in_t aimed_word();
    steer_in_t w;
    logic signed [15:0] dx, dy, vx, vy;
    int tilt;
    tilt = 1 << $urandom_range(0, 12);
    w.ox = 16'($signed($urandom_range(0, 32000)) - 16000);
    w.oy = 16'($signed($urandom_range(0, 32000)) - 16000);
    dx = 16'($signed($urandom_range(0, 16000)) - 8000);
    dy = 16'($signed($urandom_range(0, 16000)) - 8000);
    w.tx = w.ox + dx;
    w.ty = w.oy + dy;
    vx = face_toward_q ? dx : -dx;
    vy = face_toward_q ? dy : -dy;
    w.hx = -vy + 16'($signed($urandom_range(0, 2 * tilt)) - tilt);
    w.hy = -vx + 16'($signed($urandom_range(0, 2 * tilt)) - tilt);
    w.rate = any16();
    w.maxr = 15'($urandom_range(0, 32767));
    return w;
  endfunction

  function automatic steer_in_t noise_word();
    steer_in_t w;
    w = {any16(), any16(), any16(), any16(), any16(), any16(), any16(),
         15'($urandom_range(0, 32767))};
    return w;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++)
      send_word(($urandom_range(0, 3) != 0) ? aimed_word() : noise_word());
  endtask

  // result checker
  always @(posedge clk) begin
    steer_out_t e;
    if (rst_n && out_valid) begin
      if (steer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: accel %0d rate %0d stopped %0b",
                   out_turn_accel, out_turn_rate_out, out_stopped);
      end else begin
        e = steer_q.pop_front();
        if (e.accel !== out_turn_accel || e.rate !== out_turn_rate_out ||
            e.stopped !== out_stopped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp accel %0d rate %0d stopped %0b, got %0d %0d %0b",
                     e.accel, e.rate, e.stopped,
                     out_turn_accel, out_turn_rate_out, out_stopped);
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    #1;
    if (accepted_now || out_valid) wdog = 0;
    else wdog++;
    accepted_now = 1'b0;
    if (wdog >= WDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed;
    load_regs(16'd1, 16'd128, 16'd1280, 16'd256);
    send_word({16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, -16'sh8000,
               16'sh7FFF, 15'h7FFF});
    send_word({-16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 16'sh7FFF,
               -16'sh8000, 15'h0});
    // heading and target offset both zero vectors
    send_word({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd100, 15'd200});
    // heading with negative x, target behind
    send_word({16'sd0, 16'sd0, -16'sd100, 16'sd3, -16'sd50, 16'sd1, 16'sd0, 15'd500});
    // aligned exactly: stop zone
    send_word({16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, -16'sd1000, 16'sd77, 15'd900});
    // small offsets for the slow zone, both turn directions
    send_word({16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd100, -16'sd1000, -16'sd300, 15'd32767});
    send_word({16'sd0, 16'sd0, 16'sd1000, 16'sd0, -16'sd100, -16'sd1000, 16'sd300, 15'd32767});
    // flee mode
    load_regs(16'd0, 16'd128, 16'd1280, 16'd256);
    send_word({16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, -16'sd1000, 16'sd10, 15'd900});
    send_word({16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd1000, 16'sd10, 15'd900});
    // zero view angle, empty slow zone, zero time: exact alignment turns negative
    load_regs(16'd1, 16'd0, 16'd0, 16'd0);
    send_word({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 15'd1234});
    send_word({16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd90, -16'sd1000, 16'sd0, 15'd1234});
    // zero time with a live slow zone, extreme rates
    load_regs(16'd1, 16'd1, 16'd23040, 16'd0);
    send_word({16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd500, -16'sd1000, -16'sh8000, 15'h7FFF});
    send_word({16'sd0, 16'sd0, 16'sd1000, 16'sd0, -16'sd500, -16'sd1000, 16'sh7FFF, 15'h7FFF});
    // register values above range, all bits set
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word({16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd1000, 16'sd5, 15'd100});
    send_word(noise_word());
  endtask

  task automatic test_random_settings;
    load_regs(16'd1, 16'd128, 16'd1280, 16'd256);
    run_random(130);
    load_regs(16'd0, 16'd23040, 16'd23040, 16'd65535);
    run_random(100);
    load_regs(16'd1, 16'd1, 16'd23040, 16'd1);
    run_random(130);
    load_regs(16'd0, 16'd256, 16'd8000, 16'd100);
    run_random(130);
    load_regs(16'd1, 16'd0, 16'd2000, 16'd0);
    run_random(100);
    for (int p = 0; p < 3; p++) begin
      load_regs(16'($urandom_range(0, 1)), 16'($urandom_range(0, 4000)),
                16'($urandom_range(1, 23040)), 16'($urandom_range(0, 65535)));
      run_random(80);
    end
  endtask

  initial begin
    face_toward_q = 1'b1;
    view_q = 15'd128;
    outer_q = 15'd1280;
    ttv_q = 16'd256;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_settings();
    drain();
    if (mismatches == 0 && steer_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ftrs_pkg.sv
rtl/core/ftrs_cordic_cell.sv
rtl/core/ftrs_div_cell.sv
rtl/core/face_target_rotation_steer.sv
rtl/core/ftrs_checker.sv
dv/face_target_rotation_steer_test.sv
